/* design/assert_macros.svh */
// Assertion macros for the design.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* design/skx_pkg.sv */
package skx_pkg;
  localparam int SeedWidth = 64;
  localparam int CountWidth = 64;

  typedef struct packed {
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic round_last;
  } stat_t;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] le_word(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction
endpackage

/* design/sha256_counter_keystream_xor.sv */
// Channel  | Beat                  | tdata          | tuser
// s_axis   | message byte in       | [7:0] data_byte | -  (tlast = last_in_message)
// m_axis   | combined byte out     | [7:0] out_byte  | -  (tlast = out_last)
// cfg      | stream_seed write     | cfg_wdata[63:0]
// A byte whose keystream block is ready is accepted at once into the output register.
// The first byte of each 32-byte block waits for one compression: a start, 64 rounds
// and the digest update, after which it is accepted.
// Reset clears seed, counter, position and the ready flag; the digest is not cleared.
// A full output register holds s_axis_tready low until m_axis takes the beat.
`include "assert_macros.svh"
module sha256_counter_keystream_xor (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [skx_pkg::SeedWidth-1:0] cfg_wdata,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tlast,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic                          m_axis_tlast
);
  logic [skx_pkg::SeedWidth-1:0]  seed;
  logic [skx_pkg::CountWidth-1:0] counter;
  logic [4:0]                     pos;
  logic                           ready;
  logic [255:0]                   digest;
  skx_pkg::cmd_t                  cmd;
  skx_pkg::stat_t                 stat;
  logic                           busy, need, take;
  logic [7:0]                     ks;

  // Request a block only while a byte waits and the core is free.
  assign need = s_axis_tvalid && !ready && !busy;
  assign s_axis_tready = ready && !busy && (!m_axis_tvalid || m_axis_tready);
  assign take = s_axis_tvalid && s_axis_tready;
  assign ks = digest[8'd255 - {pos, 3'b000} -: 8];

  skx_ctrl u_ctrl (.clk(clk), .rst(rst), .need(need), .stat(stat), .cmd(cmd), .busy(busy));
  skx_core u_core (
    .clk(clk), .rst(rst), .cmd(cmd), .seed(seed), .counter(counter),
    .stat(stat), .digest(digest));

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      counter <= '0;
      pos <= '0;
      ready <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready) m_axis_tvalid <= 1'b0;
      if (cmd.finish) ready <= 1'b1;
      if (take) begin
        m_axis_tvalid <= 1'b1;
        if (s_axis_tlast) begin
          // message end: restart at block zero
          counter <= '0;
          pos <= '0;
          ready <= 1'b0;
        end else begin
          pos <= pos + 5'd1;
          if (pos == 5'd31) begin
            counter <= counter + {{(skx_pkg::CountWidth-1){1'b0}}, 1'b1};
            ready <= 1'b0;
          end
        end
      end
      if (cfg_we) begin
        seed <= cfg_wdata;
        ready <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      m_axis_tdata <= s_axis_tdata ^ ks;
      m_axis_tlast <= s_axis_tlast;
    end
  end

  `ASSERT_IMPL(a_no_take_busy, clk, rst, busy, !s_axis_tready)
  `ASSERT_NEXT(a_take_valid, clk, rst, take, m_axis_tvalid)
  `ASSERT_NEXT(a_last_restart, clk, rst, take && s_axis_tlast, pos == 5'd0 && !ready)
endmodule

/* design/skx_ctrl.sv */
module skx_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           need,
  input  skx_pkg::stat_t stat,
  output skx_pkg::cmd_t  cmd,
  output logic           busy
);
  typedef enum logic [1:0] {IDLE, RUN, DONE} state_t;
  state_t state;

  always_comb begin
    cmd.start = (state == IDLE) && need;
    cmd.step = (state == RUN);
    cmd.finish = (state == DONE);
    busy = (state != IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      case (state)
        IDLE: if (need) state <= RUN;
        RUN: if (stat.round_last) state <= DONE;
        DONE: state <= IDLE;
        default: state <= IDLE;
      endcase
    end
  end
endmodule

/* design/skx_core.sv */
module skx_core (
  input  logic                           clk,
  input  logic                           rst,
  input  skx_pkg::cmd_t                  cmd,
  input  logic [skx_pkg::SeedWidth-1:0]  seed,
  input  logic [skx_pkg::CountWidth-1:0] counter,
  output skx_pkg::stat_t                 stat,
  output logic [255:0]                   digest
);
  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, h;
  logic [5:0]  rnd;
  logic [31:0] s0, s1, wn, t1, t2;

  always_comb begin
    s0 = {w[1][6:0], w[1][31:7]} ^ {w[1][17:0], w[1][31:18]} ^ (w[1] >> 3);
    s1 = {w[14][16:0], w[14][31:17]} ^ {w[14][18:0], w[14][31:19]} ^ (w[14] >> 10);
    wn = s1 + w[9] + s0 + w[0];
    t1 = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & f) ^ (~e & g)) + skx_pkg::round_k(rnd) + w[0];
    t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & b) ^ (a & c) ^ (b & c));
    stat.round_last = (rnd == 6'd63);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rnd <= '0;
    end else if (cmd.start) begin
      rnd <= '0;
    end else if (cmd.step) begin
      rnd <= rnd + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      w[0] <= skx_pkg::le_word(seed[31:0]);
      w[1] <= skx_pkg::le_word(seed[63:32]);
      w[2] <= skx_pkg::le_word(counter[31:0]);
      w[3] <= skx_pkg::le_word(counter[63:32]);
      w[4] <= 32'h80000000;
      for (int i = 5; i < 15; i++) w[i] <= '0;
      w[15] <= 32'd128;
      {a, b, c, d, e, f, g, h} <= skx_pkg::InitHash;
    end else if (cmd.step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
      h <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end
    if (cmd.finish) begin
      digest <= {a + skx_pkg::InitHash[255:224], b + skx_pkg::InitHash[223:192],
                 c + skx_pkg::InitHash[191:160], d + skx_pkg::InitHash[159:128],
                 e + skx_pkg::InitHash[127:96],  f + skx_pkg::InitHash[95:64],
                 g + skx_pkg::InitHash[63:32],   h + skx_pkg::InitHash[31:0]};
    end
  end
endmodule

/* tb/sv/sha256_counter_keystream_xor_test.sv */
`timescale 1ns / 100ps
module sha256_counter_keystream_xor_test;

  // Bench-side copy of the round constants, used only by the digest predictor.
  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam int DrainCycles = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_beat_t;

  // One row of the directed table; check_ks marks rows whose keystream byte is known.
  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       check_ks;
    logic [7:0] ks;
  } directed_row_t;

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [skx_pkg::SeedWidth-1:0] cfg_wdata;
  logic                          s_axis_tvalid;
  logic                          s_axis_tready;
  logic [7:0]                    s_axis_tdata;   // [7:0] data_byte
  logic                          s_axis_tlast;
  logic                          m_axis_tvalid;
  logic                          m_axis_tready;
  logic [7:0]                    m_axis_tdata;   // [7:0] out_byte
  logic                          m_axis_tlast;

  sha256_counter_keystream_xor dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  // Predictor state: mirrors the keystream generator.
  logic [63:0] seed_shadow;
  logic [63:0] block_index;
  logic [4:0]  byte_index;
  logic [31:0] digest_words [8];
  logic        digest_valid;

  byte_beat_t  expected_bytes [$];
  int          error_count;
  bit          idle_enable;
  bit          hold_sink;
  int          hold_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Big-endian word from four little-endian bytes of v starting at byte lo.
  function automatic logic [31:0] le_to_be_word(input logic [63:0] v, input int lo);
    logic [31:0] w;
    w = '0;
    for (int i = 0; i < 4; i++) w = {w[23:0], v[8*(lo+i) +: 8]};
    return w;
  endfunction

  // SHA-256 of seed||counter (both little-endian), 128-bit message, one block.
  task automatic compute_keystream_digest(input logic [63:0] seed, input logic [63:0] ctr);
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    w[0] = le_to_be_word(seed, 0);
    w[1] = le_to_be_word(seed, 4);
    w[2] = le_to_be_word(ctr, 0);
    w[3] = le_to_be_word(ctr, 4);
    w[4] = 32'h80000000;
    for (int i = 5; i < 15; i++) w[i] = '0;
    w[15] = 32'd128;
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = s1 + w[i-7] + s0 + w[i-16];
    end
    a = StartHash[0]; b = StartHash[1]; c = StartHash[2]; d = StartHash[3];
    e = StartHash[4]; f = StartHash[5]; g = StartHash[6]; h = StartHash[7];
    for (int i = 0; i < 64; i++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + RoundK[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    digest_words[0] = StartHash[0] + a; digest_words[1] = StartHash[1] + b;
    digest_words[2] = StartHash[2] + c; digest_words[3] = StartHash[3] + d;
    digest_words[4] = StartHash[4] + e; digest_words[5] = StartHash[5] + f;
    digest_words[6] = StartHash[6] + g; digest_words[7] = StartHash[7] + h;
  endtask

  // Advance the predictor by one accepted byte; return the keystream byte used.
  task automatic predict_xor_byte(input logic [7:0] data, input logic last,
                                  output logic [7:0] ks);
    logic [31:0] word;
    if (!digest_valid) begin
      compute_keystream_digest(seed_shadow, block_index);
      digest_valid = 1'b1;
    end
    word = digest_words[byte_index[4:2]];
    ks = word[8*(3 - byte_index[1:0]) +: 8];
    expected_bytes.push_back('{data: data ^ ks, last: last});
    if (last) begin
      block_index = '0;
      byte_index = '0;
      digest_valid = 1'b0;
    end else begin
      byte_index = byte_index + 5'd1;
      if (byte_index == '0) begin
        block_index = block_index + 64'd1;
        digest_valid = 1'b0;
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [8:0] got,
                                 input logic [8:0] want);
    error_count++;
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
  endtask

  // Offer one byte and hold it until accepted; a random gap may precede it.
  task automatic send_byte(input logic [7:0] data, input logic last, output logic [7:0] ks);
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_xor_byte(data, last, ks);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    // Extra idle time; the block does not prefetch the next digest.
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write the seed while idle.
  task automatic write_seed(input logic [63:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    seed_shadow = value;
    digest_valid = 1'b0;
  endtask

  // Check each accepted output beat against the oldest expectation.
  always @(posedge clk) begin
    byte_beat_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected beat", {m_axis_tdata, m_axis_tlast}, '0);
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch("out_byte", {1'b0, m_axis_tdata}, {1'b0, want.data});
        if (m_axis_tlast !== want.last)
          report_mismatch("out_last", {8'h00, m_axis_tlast}, {8'h00, want.last});
      end
    end
  end

  // Sink backpressure: random stall bursts, a forced long hold, none near the end.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_sink = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    directed_row_t rows [$];
    logic [7:0]    ks;
    logic [63:0]   seeds [4];
    int            msg_len;
    int            sent;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    error_count = 0;
    idle_enable = 1'b0;
    hold_sink = 1'b0;
    hold_cycles = 0;
    seed_shadow = '0;
    block_index = '0;
    byte_index = '0;
    digest_valid = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: seed 0 after reset. Zero data exposes the keystream itself; data
    // extremes and a last flag at byte 0 check the restart. No row sets check_ks, so
    // every byte is checked only against the predictor.
    rows.push_back('{8'h00, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'hff, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'h55, 1'b0, 1'b0, 8'h00});
    rows.push_back('{8'haa, 1'b1, 1'b0, 8'h00});
    rows.push_back('{8'h00, 1'b1, 1'b0, 8'h00});   // single-byte message
    rows.push_back('{8'hff, 1'b1, 1'b0, 8'h00});
    foreach (rows[i]) begin
      send_byte(rows[i].data, rows[i].last, ks);
      if (rows[i].check_ks && ks !== rows[i].ks)
        report_mismatch("keystream", {1'b0, ks}, {1'b0, rows[i].ks});
    end
    // Cross a block boundary: 40 bytes, last on the final one.
    for (int i = 0; i < 40; i++) send_byte(8'(i), i == 39, ks);
    wait_drained();

    // Seed extremes, a mid-message seed change between phases.
    write_seed(64'hffff_ffff_ffff_ffff);
    for (int i = 0; i < 10; i++) send_byte(8'hff, 1'b0, ks);
    wait_drained();
    write_seed(64'h0123_4567_89ab_cdef);
    for (int i = 0; i < 30; i++) send_byte(8'($urandom), i == 29, ks);
    wait_drained();

    // Random messages, with idling on both sides except in the last phase.
    seeds[0] = '0;
    seeds[1] = '1;
    seeds[2] = {$urandom, $urandom};
    seeds[3] = 64'h8000_0000_0000_0001;
    idle_enable = 1'b1;
    sent = 0;
    for (int phase = 0; phase < 4; phase++) begin
      write_seed(phase == 0 ? {$urandom, $urandom} : seeds[phase]);
      if (phase == 1) begin
        // Long sink hold while bytes keep coming: the block must stall its input.
        hold_cycles = 300;
        hold_sink = 1'b1;
      end
      if (phase == 3) idle_enable = 1'b0;
      for (int m = 0; m < 10 || (phase < 3 && sent < 200 * (phase + 1)); m++) begin
        msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 100)
                                              : $urandom_range(1, 40);
        for (int i = 0; i < msg_len; i++) begin
          send_byte(8'($urandom), i == msg_len - 1, ks);
          sent++;
        end
        if (sent >= 760) break;
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
